// ===== rtl/core/bta_pkg.sv =====
// bta_pkg: shared types, request codes, register indexes and reset values
// for the box tracker association and steer block. No dependencies.
`default_nettype none

package bta_pkg;

    // payload widths
    localparam int FIELD_W   = 8;
    localparam int REQ_W     = 2;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int PCT_W     = 7;
    localparam int IDX_OUT_W = 6;
    localparam int TILT_W    = 8;
    localparam int DIST_W    = 2 * FIELD_W + 1;

    // parameter defaults
    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 8;
    localparam int QUEUE_DEPTH    = 4;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOCK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DET  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EOF  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_TOL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RAD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_RAD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_PCT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE_PCT   = 3'd6;

    // register reset values
    localparam logic [CFG_W-1:0] SIZE_TOL_RST   = 8'd20;
    localparam logic [CFG_W-1:0] MATCH_RAD_RST  = 8'd40;
    localparam logic [CFG_W-1:0] CENTRE_RAD_RST = 8'd20;
    localparam logic [CFG_W-1:0] CENTRE_X_RST   = 8'd88;
    localparam logic [CFG_W-1:0] CENTRE_Y_RST   = 8'd72;
    localparam logic [PCT_W-1:0] SIDE_PCT_RST   = 7'd5;
    localparam logic [PCT_W-1:0] FORE_PCT_RST   = 7'd5;

    localparam logic [PCT_W-1:0] TILT_MAX = 7'd100;

    typedef struct packed {
        logic [CFG_W-1:0] size_tol;
        logic [CFG_W-1:0] match_rad;
        logic [CFG_W-1:0] centre_rad;
        logic [CFG_W-1:0] centre_x;
        logic [CFG_W-1:0] centre_y;
        logic [PCT_W-1:0] side_pct;
        logic [PCT_W-1:0] fore_pct;
    } t_cfg;

    // classified request as it sits in the queue
    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] h;
    } t_item;

    // frame winner handed from association to steering
    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] idx;
        logic [FIELD_W-1:0]   x;
        logic [FIELD_W-1:0]   y;
        logic [FIELD_W-1:0]   w;
        logic [FIELD_W-1:0]   h;
    } t_win;

endpackage

`default_nettype wire

// ===== rtl/core/bta_req_if.sv =====
// bta_req_if: valid/ready channel carrying one tracker request.
// Depends on bta_pkg.
`default_nettype none

interface bta_req_if import bta_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [FIELD_W-1:0] box_x;
    logic [FIELD_W-1:0] box_y;
    logic [FIELD_W-1:0] box_w;
    logic [FIELD_W-1:0] box_h;

    modport source (output valid, req_type, box_x, box_y, box_w, box_h, input ready);
    modport sink   (input valid, req_type, box_x, box_y, box_w, box_h, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bta_rpt_if.sv =====
// bta_rpt_if: valid/ready channel carrying one end-of-frame report.
// Depends on bta_pkg.
`default_nettype none

interface bta_rpt_if import bta_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [IDX_OUT_W-1:0]      match_index;
    logic [FIELD_W-1:0]        ref_x;
    logic [FIELD_W-1:0]        ref_y;
    logic                      on_top;
    logic signed [TILT_W-1:0]  side_tilt;
    logic signed [TILT_W-1:0]  fore_tilt;

    modport source (output valid, found, match_index, ref_x, ref_y, on_top, side_tilt,
                    fore_tilt, input ready);
    modport sink   (input valid, found, match_index, ref_x, ref_y, on_top, side_tilt,
                    fore_tilt, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bta_front.sv =====
// bta_front: request intake. Registers each request, masks coordinates
// and drops unused request codes. Depends on bta_pkg and bta_req_if.
`default_nettype none

module bta_front import bta_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bta_req_if.sink    i_req,
    output logic       o_item_valid,
    output t_item      o_item,
    input  wire logic  i_item_ready
);

    localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam logic [FIELD_W-1:0] MASK = FIELD_W'((1 << CW) - 1);

    logic  r_vld, n_vld;
    t_item r_item;
    logic  accept;

    assign i_req.ready  = !r_vld || i_item_ready;
    assign accept       = i_req.valid && i_req.ready;
    assign o_item_valid = r_vld;
    assign o_item       = r_item;

    always_comb begin
        n_vld = r_vld;
        if (r_vld && i_item_ready) begin
            n_vld = 1'b0;
        end
        // drop the unused code here so it never reaches the queue
        if (accept && i_req.req_type != REQ_NONE) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.req_type != REQ_NONE) begin
            r_item.kind <= i_req.req_type;
            r_item.x    <= i_req.box_x & MASK;
            r_item.y    <= i_req.box_y & MASK;
            r_item.w    <= i_req.box_w & MASK;
            r_item.h    <= i_req.box_h & MASK;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bta_fifo.sv =====
// bta_fifo: small first-word-fall-through queue in flops between intake
// and association. No dependencies.
`default_nettype none

module bta_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  T          i_data,
    output logic      o_ready,
    output logic      o_valid,
    output T          o_data,
    input  wire logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [NW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_ready = r_cnt < NW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bta_assoc.sv =====
// bta_assoc: association pipeline. Gates each detection against the
// reference box, keeps the nearest candidate and folds it into the
// reference at frame end. Depends on bta_pkg.
`default_nettype none

module bta_assoc import bta_pkg::*; #(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_cfg       i_cfg,
    input  wire logic  i_item_valid,
    input  t_item      i_item,
    output logic       o_pop,
    input  wire logic  i_adv,
    output logic       o_win_valid,
    output t_win       o_win
);

    localparam int CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SQW  = 2 * CW;
    localparam int MRW  = 2 * CFG_W;
    localparam int IW   = $clog2(MAX_BOXES);
    localparam int CNTW = $clog2(MAX_BOXES + 1);
    localparam int XW   = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;

    // tracking state
    logic                r_locked;
    logic [CW-1:0]       r_ref_x, r_ref_y, r_ref_w, r_ref_h;
    logic                r_best_vld;
    logic [DIST_W-1:0]   r_best_d;
    logic [IW-1:0]       r_best_idx;
    logic [CW-1:0]       r_best_x, r_best_y, r_best_w, r_best_h;
    logic [CNTW-1:0]     r_count;

    // stage 1: differences against the reference
    logic                r1_vld, r1_live, r1_size_ok;
    logic [REQ_W-1:0]    r1_kind;
    logic [CW-1:0]       r1_x, r1_y, r1_w, r1_h, r1_dx, r1_dy;

    // stage 2: squares
    logic                r2_vld, r2_live, r2_size_ok;
    logic [REQ_W-1:0]    r2_kind;
    logic [CW-1:0]       r2_x, r2_y, r2_w, r2_h;
    logic [SQW-1:0]      r2_sqx, r2_sqy;
    logic [MRW-1:0]      r2_mr2;

    logic                r_win_vld;
    t_win                r_win;

    logic [CW-1:0]       hx, hy, hw, hh, hdx, hdy, hdw, hdh;
    logic                h_size_ok, eof_busy, head_lock;
    logic [DIST_W-1:0]   d;
    logic                cand, room, take;
    logic [XW-1:0]       idx_ext;

    assign hx = i_item.x[CW-1:0];
    assign hy = i_item.y[CW-1:0];
    assign hw = i_item.w[CW-1:0];
    assign hh = i_item.h[CW-1:0];

    always_comb begin
        hdx = (hx > r_ref_x) ? hx - r_ref_x : r_ref_x - hx;
        hdy = (hy > r_ref_y) ? hy - r_ref_y : r_ref_y - hy;
        hdw = (hw > r_ref_w) ? hw - r_ref_w : r_ref_w - hw;
        hdh = (hh > r_ref_h) ? hh - r_ref_h : r_ref_h - hh;
    end

    assign h_size_ok = (FIELD_W'(hdw) < i_cfg.size_tol) && (FIELD_W'(hdh) < i_cfg.size_tol);

    // hold the queue while a frame end is still on its way to the reference
    assign eof_busy  = (r1_vld && r1_kind == REQ_EOF) || (r2_vld && r2_kind == REQ_EOF);
    assign o_pop     = i_adv && i_item_valid && !eof_busy;
    assign head_lock = o_pop && i_item.kind == REQ_LOCK;

    assign d    = DIST_W'(r2_sqx) + DIST_W'(r2_sqy);
    assign room = r_count < CNTW'(MAX_BOXES);
    assign cand = r2_live && r2_size_ok && (d < DIST_W'(r2_mr2)) &&
                  (!r_best_vld || d < r_best_d);
    assign take = r2_vld && r2_kind == REQ_DET && r2_live && room && cand;

    assign idx_ext = XW'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked   <= 1'b0;
            r1_vld     <= 1'b0;
            r2_vld     <= 1'b0;
            r_win_vld  <= 1'b0;
            r_best_vld <= 1'b0;
            r_count    <= '0;
        end else if (i_adv) begin
            r1_vld    <= o_pop;
            r2_vld    <= r1_vld;
            r_win_vld <= r2_vld && r2_kind == REQ_EOF && r2_live;
            if (head_lock) begin
                r_locked <= 1'b1;
            end
            if (r2_vld) begin
                case (r2_kind)
                    REQ_LOCK: begin
                        r_best_vld <= 1'b0;
                        r_count    <= '0;
                    end
                    REQ_DET: begin
                        if (r2_live && room) begin
                            if (cand) begin
                                r_best_vld <= 1'b1;
                            end
                            r_count <= r_count + 1'b1;
                        end
                    end
                    REQ_EOF: begin
                        if (r2_live) begin
                            r_best_vld <= 1'b0;
                            r_count    <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_kind    <= i_item.kind;
            r1_x       <= hx;
            r1_y       <= hy;
            r1_w       <= hw;
            r1_h       <= hh;
            r1_dx      <= hdx;
            r1_dy      <= hdy;
            r1_live    <= r_locked;
            r1_size_ok <= h_size_ok;

            r2_kind    <= r1_kind;
            r2_x       <= r1_x;
            r2_y       <= r1_y;
            r2_w       <= r1_w;
            r2_h       <= r1_h;
            r2_live    <= r1_live;
            r2_size_ok <= r1_size_ok;
            r2_sqx     <= SQW'(r1_dx) * SQW'(r1_dx);
            r2_sqy     <= SQW'(r1_dy) * SQW'(r1_dy);
            r2_mr2     <= MRW'(i_cfg.match_rad) * MRW'(i_cfg.match_rad);

            if (take) begin
                r_best_d   <= d;
                r_best_idx <= r_count[IW-1:0];
                r_best_x   <= r2_x;
                r_best_y   <= r2_y;
                r_best_w   <= r2_w;
                r_best_h   <= r2_h;
            end

            // lock loads the reference on entry; frame end folds in the winner
            if (head_lock) begin
                r_ref_x <= hx;
                r_ref_y <= hy;
                r_ref_w <= hw;
                r_ref_h <= hh;
            end else if (r2_vld && r2_kind == REQ_EOF && r2_live && r_best_vld) begin
                r_ref_x <= r_best_x;
                r_ref_y <= r_best_y;
                r_ref_w <= r_best_w;
                r_ref_h <= r_best_h;
            end

            r_win.found <= r_best_vld;
            r_win.idx   <= r_best_vld ? idx_ext[IDX_OUT_W-1:0] : '0;
            r_win.x     <= FIELD_W'(r_best_vld ? r_best_x : r_ref_x);
            r_win.y     <= FIELD_W'(r_best_vld ? r_best_y : r_ref_y);
            r_win.w     <= FIELD_W'(r_best_w);
            r_win.h     <= FIELD_W'(r_best_h);
        end
    end

    assign o_win_valid = r_win_vld;
    assign o_win       = r_win;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_BOXES))
        else $error("box count past frame limit");

    a_best_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_vld |-> (r_count > CNTW'(r_best_idx)))
        else $error("winner index not among boxes seen");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r2_vld && r2_kind == REQ_EOF && r2_live) |=> !r_best_vld)
        else $error("frame end left a winner behind");

    a_win_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_win_valid |-> r_locked)
        else $error("report raised before any lock");

endmodule

`default_nettype wire

// ===== rtl/core/bta_steer.sv =====
// bta_steer: report pipeline. Tests the winner centre against the image
// centre, forms tilt commands and holds the report. Depends on bta_pkg, bta_rpt_if.
`default_nettype none

module bta_steer import bta_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_cfg       i_cfg,
    input  wire logic  i_win_valid,
    input  t_win       i_win,
    output logic       o_adv,
    bta_rpt_if.source  o_rpt
);

    localparam int CXW = FIELD_W + 1;
    localparam int SQW = 2 * CXW;
    localparam int SMW = SQW + 1;
    localparam int CRW = 2 * CFG_W;

    function automatic logic [TILT_W-1:0] steer_tilt(input logic gt, input logic lt,
                                                     input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0] mag;
        mag = (pct > TILT_MAX) ? TILT_MAX : pct;
        if (gt) begin
            return TILT_W'(mag);
        end else if (lt) begin
            return TILT_W'(0) - TILT_W'(mag);
        end
        return '0;
    endfunction

    logic                 t1_vld, t1_found, t1_gx, t1_lx, t1_gy, t1_ly;
    logic [IDX_OUT_W-1:0] t1_idx;
    logic [FIELD_W-1:0]   t1_x, t1_y;
    logic [CXW-1:0]       t1_dcx, t1_dcy;

    logic                 t2_vld, t2_found, t2_gx, t2_lx, t2_gy, t2_ly;
    logic [IDX_OUT_W-1:0] t2_idx;
    logic [FIELD_W-1:0]   t2_x, t2_y;
    logic [SQW-1:0]       t2_sqx, t2_sqy;
    logic [CRW-1:0]       t2_cr2;

    logic                 r_out_vld, r_found, r_on_top;
    logic [IDX_OUT_W-1:0] r_idx;
    logic [FIELD_W-1:0]   r_ref_x, r_ref_y;
    logic [TILT_W-1:0]    r_side, r_fore;

    logic [CXW-1:0]       cx, cy, ctr_x, ctr_y, dcx, dcy;
    logic [SMW-1:0]       sum;
    logic                 top;

    assign o_adv = !r_out_vld || o_rpt.ready;

    assign cx    = CXW'(i_win.x) + CXW'(i_win.w >> 1);
    assign cy    = CXW'(i_win.y) + CXW'(i_win.h >> 1);
    assign ctr_x = CXW'(i_cfg.centre_x);
    assign ctr_y = CXW'(i_cfg.centre_y);
    assign dcx   = (cx > ctr_x) ? cx - ctr_x : ctr_x - cx;
    assign dcy   = (cy > ctr_y) ? cy - ctr_y : ctr_y - cy;

    assign sum = SMW'(t2_sqx) + SMW'(t2_sqy);
    assign top = t2_found && (sum < SMW'(t2_cr2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            t1_vld    <= 1'b0;
            t2_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            t1_vld    <= i_win_valid;
            t2_vld    <= t1_vld;
            r_out_vld <= t2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            t1_found <= i_win.found;
            t1_idx   <= i_win.idx;
            t1_x     <= i_win.x;
            t1_y     <= i_win.y;
            t1_dcx   <= dcx;
            t1_dcy   <= dcy;
            t1_gx    <= cx > ctr_x;
            t1_lx    <= cx < ctr_x;
            t1_gy    <= cy > ctr_y;
            t1_ly    <= cy < ctr_y;

            t2_found <= t1_found;
            t2_idx   <= t1_idx;
            t2_x     <= t1_x;
            t2_y     <= t1_y;
            t2_gx    <= t1_gx;
            t2_lx    <= t1_lx;
            t2_gy    <= t1_gy;
            t2_ly    <= t1_ly;
            t2_sqx   <= SQW'(t1_dcx) * SQW'(t1_dcx);
            t2_sqy   <= SQW'(t1_dcy) * SQW'(t1_dcy);
            t2_cr2   <= CRW'(i_cfg.centre_rad) * CRW'(i_cfg.centre_rad);

            r_found  <= t2_found;
            r_idx    <= t2_idx;
            r_ref_x  <= t2_x;
            r_ref_y  <= t2_y;
            r_on_top <= top;
            // steer only when a box was found and it is off centre
            r_side   <= (t2_found && !top) ? steer_tilt(t2_gx, t2_lx, i_cfg.side_pct) : '0;
            r_fore   <= (t2_found && !top) ? steer_tilt(t2_gy, t2_ly, i_cfg.fore_pct) : '0;
        end
    end

    assign o_rpt.valid       = r_out_vld;
    assign o_rpt.found       = r_found;
    assign o_rpt.match_index = r_idx;
    assign o_rpt.ref_x       = r_ref_x;
    assign o_rpt.ref_y       = r_ref_y;
    assign o_rpt.on_top      = r_on_top;
    assign o_rpt.side_tilt   = $signed(r_side);
    assign o_rpt.fore_tilt   = $signed(r_fore);

    a_miss_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_found) |->
            (r_idx == '0 && !r_on_top && r_side == '0 && r_fore == '0))
        else $error("report without a match carries data");

    a_top_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_on_top) |-> (r_side == '0 && r_fore == '0))
        else $error("tilt issued while on top");

endmodule

`default_nettype wire

// ===== rtl/core/box_tracker_association_steer.sv =====
// box_tracker_association_steer: top level of the frame-to-frame box tracker.
// Depends on bta_pkg, bta_req_if, bta_rpt_if, bta_front, bta_fifo, bta_assoc, bta_steer.
//
// A lock request loads the reference box and opens a frame; detection
// requests then stream in, one box per request, and each is gated on width
// and height (strictly within size_tolerance of the reference) and on corner
// distance (squared, strictly within match_radius squared). The nearest
// candidate wins and the earliest wins a tie; boxes past MAX_BOXES in a
// frame are dropped. An end-of-frame request folds the winner into the
// reference and raises one report with found, match_index, the new
// reference corner, on_top and signed tilt commands toward
// (centre_x, centre_y). Detection and end-of-frame requests before the first
// lock, and request type 3, produce nothing. Rate: one request per clock
// while the report is not stalled, except that the request following an
// end-of-frame waits while the frame end passes the two-stage distance
// pipeline and updates the reference. With nothing stalled, an end-of-frame
// request passes the intake register, queue, two association stages, winner
// register, two steering stages and the report register before its report is
// valid; the intake register loads at the accepting edge. A stalled report
// freezes the back end; the queue keeps taking requests until it fills. Write
// configuration only while the block is idle.
`default_nettype none

module box_tracker_association_steer import bta_pkg::*; #(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bta_req_if.sink                   i_req,
    bta_rpt_if.source                 o_rpt,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg  r_cfg;

    logic  front_valid, queue_ready;
    t_item front_item;
    logic  queue_valid, queue_pop;
    t_item queue_item;
    logic  adv;
    logic  win_valid;
    t_win  win;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_tol   <= SIZE_TOL_RST;
            r_cfg.match_rad  <= MATCH_RAD_RST;
            r_cfg.centre_rad <= CENTRE_RAD_RST;
            r_cfg.centre_x   <= CENTRE_X_RST;
            r_cfg.centre_y   <= CENTRE_Y_RST;
            r_cfg.side_pct   <= SIDE_PCT_RST;
            r_cfg.fore_pct   <= FORE_PCT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE_TOL:   r_cfg.size_tol   <= i_cfg_data;
                CFG_MATCH_RAD:  r_cfg.match_rad  <= i_cfg_data;
                CFG_CENTRE_RAD: r_cfg.centre_rad <= i_cfg_data;
                CFG_CENTRE_X:   r_cfg.centre_x   <= i_cfg_data;
                CFG_CENTRE_Y:   r_cfg.centre_y   <= i_cfg_data;
                CFG_SIDE_PCT:   r_cfg.side_pct   <= i_cfg_data[PCT_W-1:0];
                CFG_FORE_PCT:   r_cfg.fore_pct   <= i_cfg_data[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // intake: register, mask, drop unused codes
    bta_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_item_valid (front_valid),
        .o_item       (front_item),
        .i_item_ready (queue_ready)
    );

    // decouple intake from the association pipeline
    bta_fifo #(
        .T     (t_item),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_item),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_data  (queue_item),
        .i_pop   (queue_pop)
    );

    // gate, rank and fold the winner into the reference
    bta_assoc #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_assoc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (queue_valid),
        .i_item       (queue_item),
        .o_pop        (queue_pop),
        .i_adv        (adv),
        .o_win_valid  (win_valid),
        .o_win        (win)
    );

    // centre test, tilt and report register
    bta_steer u_steer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_win_valid (win_valid),
        .i_win       (win),
        .o_adv       (adv),
        .o_rpt       (o_rpt)
    );

endmodule

`default_nettype wire
